/* rtl/core/rbst_pkg.sv */
// Shared types and constants for the ray versus box slab test.
// No dependencies; imported by every module of the block.
package rbst_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_T    = 3'd6;

  localparam int ADDR_W = 5;

  // Divider: one quotient bit per stage plus range check and saturation
  localparam int QUO_W   = 32;
  localparam int DIV_LAT = QUO_W + 2;

  // Crossing parameters widened by one bit to hold the open-ended markers
  localparam logic signed [32:0] T_SAT_HI  = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] T_SAT_LO  = -33'sh0_8000_0000;
  localparam logic signed [32:0] T_NEG_INF = -33'sh0_8000_0001;
  localparam logic signed [32:0] T_POS_INF = 33'sh0_8000_0000;

  // Face axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Held ray
  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][31:0] dir;
    logic [31:0]      max_t;
  } cfg_t;

  // Control carried alongside the divider lanes
  typedef struct packed {
    logic       valid;
    logic [2:0] par_miss;
  } ctl_t;

endpackage

/* rtl/core/rbst_regs.sv */
// APB-style configuration registers holding the ray.
// Depends on rbst_pkg.
module rbst_regs import rbst_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t        cfg_r;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin <= '0;
      cfg_r.dir    <= {32'd0, 32'd0, 32'd65536};
      cfg_r.max_t  <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_X: cfg_r.origin[0] <= pwdata;
        REG_ORIGIN_Y: cfg_r.origin[1] <= pwdata;
        REG_ORIGIN_Z: cfg_r.origin[2] <= pwdata;
        REG_DIR_X:    cfg_r.dir[0]    <= pwdata;
        REG_DIR_Y:    cfg_r.dir[1]    <= pwdata;
        REG_DIR_Z:    cfg_r.dir[2]    <= pwdata;
        REG_MAX_T:    cfg_r.max_t     <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = cfg_r.origin[0];
      REG_ORIGIN_Y: prdata = cfg_r.origin[1];
      REG_ORIGIN_Z: prdata = cfg_r.origin[2];
      REG_DIR_X:    prdata = cfg_r.dir[0];
      REG_DIR_Y:    prdata = cfg_r.dir[1];
      REG_DIR_Z:    prdata = cfg_r.dir[2];
      REG_MAX_T:    prdata = cfg_r.max_t;
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/core/rbst_div.sv */
// Pipelined restoring divider for one crossing parameter, one quotient bit per stage,
// with saturation to the signed 32-bit range. Depends on rbst_pkg.
module rbst_div import rbst_pkg::*; #(
  parameter int NUM_W = 49
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NUM_W-1:0]         num_mag,
  input  logic                     neg,
  input  logic [31:0]              den_mag,
  output logic signed [31:0]       t_out
);

  logic [NUM_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             neg_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  logic [31:0]      t_r;
  logic [63:0]      den_w;

  assign den_w = {32'd0, den_mag};
  assign t_out = t_r;

  // range check: quotient does not fit in QUO_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_mag;
      quo_r[0] <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= (64'(num_mag) >= (den_w << QUO_W));
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - k;
    logic [63:0]      trial;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    always_comb begin
      trial   = den_w << SH;
      ge      = (64'(rem_r[k-1]) >= trial);
      rem_nxt = ge ? (rem_r[k-1] - NUM_W'(trial)) : rem_r[k-1];
      quo_nxt = quo_r[k-1];
      quo_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  // sign and saturation
  logic [31:0] t_nxt;
  logic [31:0] uq;

  always_comb begin
    uq = quo_r[QUO_W];
    if (!neg_r[QUO_W]) begin
      t_nxt = (ovf_r[QUO_W] || uq[31]) ? 32'h7FFF_FFFF : uq;
    end else begin
      t_nxt = (ovf_r[QUO_W] || (uq > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - uq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

endmodule

/* rtl/core/rbst_combine.sv */
// Slab ordering, per-axis combining and hit decision: three register stages.
// Depends on rbst_pkg.
module rbst_combine import rbst_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [5:0][31:0]        t_lane,
  input  logic [2:0]              par_miss,
  input  cfg_t                    cfg,
  output logic                    hit,
  output logic [31:0]             entry_t,
  output logic [1:0]              face_axis,
  output logic                    normal_positive
);

  // stage B: ordered crossings per axis
  logic signed [32:0] t1_r [0:2];
  logic signed [32:0] t2_r [0:2];
  logic [2:0]         sw_r;
  logic [2:0]         pm_b_r;

  logic signed [32:0] t1_nxt [0:2];
  logic signed [32:0] t2_nxt [0:2];
  logic [2:0]         sw_nxt;
  logic signed [32:0] ta;
  logic signed [32:0] tb;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ta = {t_lane[a][31], t_lane[a]};
      tb = {t_lane[a+3][31], t_lane[a+3]};
      if (cfg.dir[a] == 32'd0) begin
        t1_nxt[a] = T_NEG_INF;
        t2_nxt[a] = T_POS_INF;
        sw_nxt[a] = 1'b0;
      end else if (ta > tb) begin
        t1_nxt[a] = tb;
        t2_nxt[a] = ta;
        sw_nxt[a] = 1'b1;
      end else begin
        t1_nxt[a] = ta;
        t2_nxt[a] = tb;
        sw_nxt[a] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t1_nxt;
      t2_r   <= t2_nxt;
      sw_r   <= sw_nxt;
      pm_b_r <= par_miss;
    end
  end

  // stage C: largest entry (earliest axis wins ties), smallest exit
  logic signed [32:0] tmin_r, tmax_r, tmin_nxt, tmax_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               up_r, up_nxt;
  logic               pm_c_r;

  always_comb begin
    tmin_nxt = T_NEG_INF;
    tmax_nxt = T_POS_INF;
    axis_nxt = AXIS_X;
    up_nxt   = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (t1_r[a] > tmin_nxt) begin
        tmin_nxt = t1_r[a];
        axis_nxt = 2'(a);
        up_nxt   = sw_r[a];
      end
      if (t2_r[a] < tmax_nxt) begin
        tmax_nxt = t2_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
      axis_r <= axis_nxt;
      up_r   <= up_nxt;
      pm_c_r <= |pm_b_r;
    end
  end

  // stage D: hit decision into the output register
  logic        hit_r, hit_nxt;
  logic [31:0] entry_r;
  logic [1:0]  axis_o_r;
  logic        up_o_r;
  logic        zero_dir;

  always_comb begin
    zero_dir = (cfg.dir[0] == 32'd0) && (cfg.dir[1] == 32'd0) && (cfg.dir[2] == 32'd0);
    hit_nxt  = !zero_dir && !pm_c_r && (tmin_r <= tmax_r) && !tmax_r[32]
               && ($signed({tmin_r[32], tmin_r}) <= $signed({2'b00, cfg.max_t}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r    <= hit_nxt;
      entry_r  <= (hit_nxt && !tmin_r[32]) ? tmin_r[31:0] : 32'd0;
      axis_o_r <= hit_nxt ? axis_r : AXIS_X;
      up_o_r   <= hit_nxt && up_r;
    end
  end

  assign hit             = hit_r;
  assign entry_t         = entry_r;
  assign face_axis       = axis_o_r;
  assign normal_positive = up_o_r;

endmodule

/* rtl/core/ray_box_slab_test.sv */
// Ray versus axis-aligned box slab test: top level.
// Depends on rbst_pkg, rbst_regs, rbst_div, rbst_combine.
//
// The ray (origin, direction, limit) sits in APB registers; each input
// transaction is one box and yields one result transaction. The pipeline takes
// a box every cycle unless stalled; the pipeline depth comes from the six
// parallel dividers, which resolve one quotient bit per stage. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so a stall holds every stage in place. Configuration may only change
// while no transaction is in flight.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [31:0]       out_entry_t,
  output logic [1:0]        out_face_axis,
  output logic              out_normal_positive
);

  localparam int NUM_W = 33 + FRAC_BITS;

  cfg_t cfg;
  logic en;

  rbst_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg (cfg)
  );

  // pipeline advances when the output register is free or draining
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front stage: plane offsets scaled into divider numerators
  logic [31:0]      bnd   [0:5];
  logic [NUM_W-1:0] num_nxt [0:5];
  logic [5:0]       neg_nxt;
  logic [2:0]       pm_nxt;
  logic [NUM_W-1:0] num_r [0:5];
  logic [5:0]       neg_r;
  logic [2:0][31:0] den_mag;
  logic signed [32:0] diff;
  logic [32:0]      dmag;

  always_comb begin
    bnd[0] = in_box_min_x; bnd[1] = in_box_min_y; bnd[2] = in_box_min_z;
    bnd[3] = in_box_max_x; bnd[4] = in_box_max_y; bnd[5] = in_box_max_z;
    for (int a = 0; a < 3; a++) begin
      den_mag[a] = cfg.dir[a][31] ? (32'd0 - cfg.dir[a]) : cfg.dir[a];
      // only a parallel axis can miss on the origin's slab position
      pm_nxt[a]  = (cfg.dir[a] == 32'd0)
                   && (($signed(cfg.origin[a]) < $signed(bnd[a]))
                       || ($signed(cfg.origin[a]) > $signed(bnd[a+3])));
    end
    for (int j = 0; j < 6; j++) begin
      diff       = $signed({bnd[j][31], bnd[j]})
                   - $signed({cfg.origin[j%3][31], cfg.origin[j%3]});
      dmag       = diff[32] ? (33'd0 - diff) : diff;
      num_nxt[j] = NUM_W'(dmag) << FRAC_BITS;
      neg_nxt[j] = diff[32] ^ cfg.dir[j%3][31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      neg_r <= neg_nxt;
    end
  end

  // control travelling beside the divider lanes
  ctl_t ctl_r [0:DIV_LAT];
  logic vb_r, vc_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_LAT; s++) ctl_r[s].valid <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= {in_valid, pm_nxt};
      for (int s = 1; s <= DIV_LAT; s++) ctl_r[s] <= ctl_r[s-1];
      vb_r        <= ctl_r[DIV_LAT].valid;
      vc_r        <= vb_r;
      out_valid_r <= vc_r;
    end
  end

  assign out_valid = out_valid_r;

  // six crossing dividers: lower planes then upper planes
  logic [5:0][31:0] t_lane;

  for (genvar j = 0; j < 6; j++) begin : g_lane
    rbst_div #(.NUM_W(NUM_W)) u_div (
      .clk,
      .en,
      .num_mag (num_r[j]),
      .neg     (neg_r[j]),
      .den_mag (den_mag[j%3]),
      .t_out   (t_lane[j])
    );
  end

  rbst_combine u_comb (
    .clk,
    .en,
    .t_lane          (t_lane),
    .par_miss        (ctl_r[DIV_LAT].par_miss),
    .cfg             (cfg),
    .hit             (out_hit),
    .entry_t         (out_entry_t),
    .face_axis       (out_face_axis),
    .normal_positive (out_normal_positive)
  );

endmodule

/* rtl/core/rbst_checker.sv */
// Port-level checks for ray_box_slab_test, bound to the top level.
// Depends on rbst_pkg.
module rbst_checker import rbst_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_entry_t,
  input logic [1:0]  out_face_axis,
  input logic        out_normal_positive
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_t) && $stable(out_hit))
    else $error("result changed while stalled");

  // a miss carries zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_entry_t == 32'd0 && out_face_axis == AXIS_X
                              && !out_normal_positive)
    else $error("miss with nonzero fields");

  // face axis code in range on a hit
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_face_axis == AXIS_X || out_face_axis == AXIS_Y
                             || out_face_axis == AXIS_Z)
    else $error("bad face axis");

  // an empty output register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // nothing emerges right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_hit, .out_entry_t,
  .out_face_axis, .out_normal_positive
);
